### src/cle_pkg.sv
// Package for the closed-loop edge chainer.
// Holds the stored edge record, the result item and the sequencer states.
// No dependencies.
`default_nettype none

package cle_pkg;

  localparam int PointWidth  = 8;
  localparam int KindWidth   = 2;
  localparam int SourceWidth = 5;

  typedef struct packed {
    logic [PointWidth-1:0]  a;
    logic [PointWidth-1:0]  b;
    logic [KindWidth-1:0]   kind;
    logic [SourceWidth-1:0] src;
  } edge_rec_t;

  localparam int EdgeRecWidth = $bits(edge_rec_t);

  typedef struct packed {
    logic [PointWidth-1:0]  from_point;
    logic [PointWidth-1:0]  to_point;
    logic [KindWidth-1:0]   edge_kind;
    logic [SourceWidth-1:0] edge_source;
    logic                   reversed;
    logic                   loop_end;
    logic                   done_res;
    logic                   overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_HEAD,
    S_SCAN,
    S_COMPARE,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_EDGE,
    S_EMIT_OUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### src/cle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while no read is enabled. No dependencies.
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/cle_out_stage.sv
// Output register of the closed-loop edge chainer.
// Holds one result item until the consumer takes it; uses cle_pkg.
`default_nettype none

module cle_out_stage
  import cle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_item,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      item
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      item <= load_item;
    end
  end

endmodule

`default_nettype wire

### src/closed_loop_edge_chainer.sv
// Top level of the closed-loop edge chainer.
// Uses cle_pkg, cle_ram (edge table and chain buffer) and cle_out_stage.
//
// Edges load one per cycle into the edge memory. After the last edge the
// block chains them into loops. A start that is already used is skipped,
// and a fresh start reads its edge, loads the head and, after the sweeps,
// checks for closure. Each sweep over the table skips used entries and
// reads and then compares each unused one, since each compare waits on the
// registered read of the single edge memory port. Sweeps repeat until one
// adds nothing. Each loop edge then leaves through a chain buffer read, an
// edge read and an output load, the load waiting while the output register
// is busy. A final start check leads to the done item, which carries the
// overflow flag. No edge is accepted while chaining or emitting.
`default_nettype none

module closed_loop_edge_chainer
  import cle_pkg::*;
#(
  parameter int MAX_EDGES = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PointWidth-1:0]  start_point,
  input  wire logic [PointWidth-1:0]  end_point,
  input  wire logic [KindWidth-1:0]   kind,
  input  wire logic [SourceWidth-1:0] source_index,
  input  wire logic                   ignore,
  input  wire logic                   last_edge,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PointWidth-1:0]       from_point,
  output logic [PointWidth-1:0]       to_point,
  output logic [KindWidth-1:0]        edge_kind,
  output logic [SourceWidth-1:0]      edge_source,
  output logic                        reversed,
  output logic                        loop_end,
  output logic                        done_res,
  output logic                        overflow
);

  localparam int IW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_EDGES);
  localparam logic [CW-1:0] One = CW'(1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic overflow_flag, overflow_flag_next;
  logic [MAX_EDGES-1:0] used, used_next;
  logic [CW-1:0] s, s_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] k, k_next;
  logic [PointWidth-1:0] head, head_next;
  logic [PointWidth-1:0] tail, tail_next;
  logic grew, grew_next;

  logic edge_we, edge_re;
  logic [IW-1:0] edge_waddr, edge_raddr;
  edge_rec_t edge_wdata, edge_rdata;
  logic cb_we, cb_re;
  logic [IW-1:0] cb_waddr, cb_raddr;
  logic [IW:0] cb_wdata, cb_rdata;

  logic [IW-1:0] used_addr;
  logic used_hit;
  logic out_load, out_free;
  result_t out_item, res;

  cle_ram #(.WIDTH(EdgeRecWidth), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .re    (edge_re),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  cle_ram #(.WIDTH(IW + 1), .DEPTH(MAX_EDGES)) u_chain_ram (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (cb_wdata),
    .re    (cb_re),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  cle_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_item (out_item),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (res)
  );

  assign from_point  = res.from_point;
  assign to_point    = res.to_point;
  assign edge_kind   = res.edge_kind;
  assign edge_source = res.edge_source;
  assign reversed    = res.reversed;
  assign loop_end    = res.loop_end;
  assign done_res    = res.done_res;
  assign overflow    = res.overflow;

  assign used_addr = (state == S_START) ? s[IW-1:0] : i[IW-1:0];
  assign used_hit  = used[used_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      overflow_flag <= 1'b0;
      used          <= '0;
      s             <= '0;
      i             <= '0;
      len           <= '0;
      k             <= '0;
      grew          <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_flag <= overflow_flag_next;
      used          <= used_next;
      s             <= s_next;
      i             <= i_next;
      len           <= len_next;
      k             <= k_next;
      grew          <= grew_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    overflow_flag_next = overflow_flag;
    used_next          = used;
    s_next             = s;
    i_next             = i;
    len_next           = len;
    k_next             = k;
    head_next          = head;
    tail_next          = tail;
    grew_next          = grew;
    in_ready           = 1'b0;
    edge_we            = 1'b0;
    edge_waddr         = count[IW-1:0];
    edge_wdata         = '{a: start_point, b: end_point, kind: kind, src: source_index};
    edge_re            = 1'b0;
    edge_raddr         = i[IW-1:0];
    cb_we              = 1'b0;
    cb_waddr           = len[IW-1:0];
    cb_wdata           = {1'b0, i[IW-1:0]};
    cb_re              = 1'b0;
    cb_raddr           = k[IW-1:0];
    out_load           = 1'b0;
    out_item           = '0;

    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!ignore) begin
            if (count < MaxCount) begin
              edge_we    = 1'b1;
              count_next = count + One;
            end else begin
              overflow_flag_next = 1'b1;
            end
          end
          if (last_edge) begin
            s_next     = '0;
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (s >= count) begin
          state_next = S_DONE;
        end else if (used_hit) begin
          s_next = s + One;
        end else begin
          edge_re                = 1'b1;
          edge_raddr             = s[IW-1:0];
          used_next[s[IW-1:0]]   = 1'b1;
          state_next             = S_HEAD;
        end
      end
      S_HEAD: begin
        head_next  = edge_rdata.a;
        tail_next  = edge_rdata.b;
        cb_we      = 1'b1;
        cb_waddr   = '0;
        cb_wdata   = {1'b0, s[IW-1:0]};
        len_next   = One;
        i_next     = '0;
        grew_next  = 1'b0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (i >= count) begin
          if (grew) begin
            i_next    = '0;
            grew_next = 1'b0;
          end else begin
            state_next = S_CHECK;
          end
        end else if (used_hit) begin
          i_next = i + One;
        end else begin
          edge_re    = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (edge_rdata.a == tail && edge_rdata.b != tail) begin
          cb_we                = 1'b1;
          cb_wdata             = {1'b0, i[IW-1:0]};
          len_next             = len + One;
          tail_next            = edge_rdata.b;
          used_next[i[IW-1:0]] = 1'b1;
          grew_next            = 1'b1;
        end else if (edge_rdata.b == tail && edge_rdata.a != tail) begin
          cb_we                = 1'b1;
          cb_wdata             = {1'b1, i[IW-1:0]};
          len_next             = len + One;
          tail_next            = edge_rdata.a;
          used_next[i[IW-1:0]] = 1'b1;
          grew_next            = 1'b1;
        end
        i_next     = i + One;
        state_next = S_SCAN;
      end
      S_CHECK: begin
        if (len >= CW'(2) && tail == head) begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end else begin
          s_next     = s + One;
          state_next = S_START;
        end
      end
      S_EMIT_RD: begin
        cb_re      = 1'b1;
        state_next = S_EMIT_EDGE;
      end
      S_EMIT_EDGE: begin
        edge_re    = 1'b1;
        edge_raddr = cb_rdata[IW-1:0];
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        out_item.from_point  = cb_rdata[IW] ? edge_rdata.b : edge_rdata.a;
        out_item.to_point    = cb_rdata[IW] ? edge_rdata.a : edge_rdata.b;
        out_item.edge_kind   = edge_rdata.kind;
        out_item.edge_source = edge_rdata.src;
        out_item.reversed    = cb_rdata[IW];
        out_item.loop_end    = (k + One == len);
        if (out_free) begin
          out_load = 1'b1;
          k_next   = k + One;
          if (k + One == len) begin
            s_next     = s + One;
            state_next = S_START;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_DONE: begin
        out_item.done_res = 1'b1;
        out_item.overflow = overflow_flag;
        if (out_free) begin
          out_load           = 1'b1;
          count_next         = '0;
          overflow_flag_next = 1'b0;
          used_next          = '0;
          state_next         = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCount)
    else $error("edge count exceeds table capacity");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (count == '0 && used == '0 && !overflow_flag))
    else $error("run state not cleared after the done item");

  a_chain_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_CHECK) |-> (len <= count && len != '0))
    else $error("chain length out of range");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!loop_end && !reversed && from_point == '0))
    else $error("done item carries edge fields");

  a_loop_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_OUT) |-> (k < len))
    else $error("emit index beyond chain length");
`endif

endmodule

`default_nettype wire
